>>> sv/dss_pkg.sv
// Package: shared types and constants for the disk seek scheduler
package dss_pkg;
   localparam int BatchDepth = 8;
   localparam logic [1:0] ALG_FCFS  = 2'd0;
   localparam logic [1:0] ALG_SSTF  = 2'd1;
   localparam logic [1:0] ALG_CLOOK = 2'd2;
   localparam logic [1:0] ALG_CSCAN = 2'd3;
   localparam logic [1:0] CSR_ALGORITHM = 2'd0;
   localparam logic [1:0] CSR_MAX_CYL   = 2'd1;
   localparam logic [1:0] CSR_START     = 2'd2;
   localparam logic [15:0] MAX_CYL_RESET = 16'd1999;
   localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

   typedef struct packed {
      logic [15:0] cylinder;
      logic        last_request;
   } req_type;

   typedef struct packed {
      logic [15:0] served_cylinder;
      logic [17:0] step_distance;
      logic [23:0] total_distance;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic        sel_found;
      logic [15:0] sel_cyl;
      logic [15:0] sel_dist;
      logic        wrap_found;
      logic [15:0] wrap_cyl;
   } pick_type;

   typedef struct packed {
      logic take_sel;
      logic take_wrap;
   } take_type;

   function automatic logic [15:0] abs_diff(logic [15:0] a, logic [15:0] b);
      return (a > b) ? a - b : b - a;
   endfunction
endpackage

>>> sv/dss_pick.sv
// Candidate compare: decides whether a scanned entry replaces the best so far
module dss_pick (
   input  logic [1:0]        alg,
   input  logic [15:0]       head,
   input  logic              cand_ok,
   input  logic [15:0]       cand_cyl,
   input  dss_pkg::pick_type cur,
   output dss_pkg::take_type take
);
   logic [15:0] d;
   assign d = dss_pkg::abs_diff(head, cand_cyl);

   always_comb begin
      take.take_sel  = 1'b0;
      take.take_wrap = 1'b0;
      if (cand_ok) begin
         unique case (alg)
            dss_pkg::ALG_FCFS: take.take_sel = !cur.sel_found;
            dss_pkg::ALG_SSTF: take.take_sel = !cur.sel_found || d < cur.sel_dist ||
                                  (d == cur.sel_dist && cand_cyl < cur.sel_cyl);
            default: begin
               take.take_sel  = cand_cyl <= head && (!cur.sel_found || cand_cyl > cur.sel_cyl);
               take.take_wrap = !cur.wrap_found || cand_cyl > cur.wrap_cyl;
            end
         endcase
      end
   end
endmodule

>>> sv/disk_seek_scheduler.sv
// Top level: batch store memory, scan sequencer and result register
// Loading takes one cycle per request item; the closing item starts the service order.
// Each result takes a full scan of the store memory, reading all n stored items,
// so a batch of n requests emits its n results after n full scans, one per result.
// The store memory is read through a registered read port.
// Reset (synchronous): empty batch, head 0, algorithm FCFS, max cylinder 1999.
module disk_seek_scheduler #(
   parameter int BATCH_DEPTH = dss_pkg::BatchDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dss_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   localparam int CW = $clog2(BATCH_DEPTH + 1);
   localparam int IW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
   localparam logic [1:0] S_LOAD = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [15:0] mem [BATCH_DEPTH];
   logic [1:0]  state_ff;
   logic [1:0]  alg_ff;
   logic [15:0] max_ff, head_ff;
   logic [CW-1:0] count_ff, n_ff, issue_ff, k_ff, count_in;
   logic [BATCH_DEPTH-1:0] marks_ff;
   logic          rd_valid_ff;
   logic [IW-1:0] rd_idx_ff, sel_idx_ff, wrap_idx_ff, best_idx;
   logic [15:0]   rd_data_ff, clamped, best_cyl;
   dss_pkg::pick_type pick_ff;
   dss_pkg::take_type take;
   logic [23:0] total_ff;
   logic        rsp_valid_ff;
   dss_pkg::rsp_type rsp_ff, rsp_in;
   logic issuing, cand_ok, accept, close, emit;
   logic [19:0] dist20;
   logic        dist_neg;
   logic [24:0] sum;

   assign req_ready = state_ff == S_LOAD;
   assign accept    = req_valid && req_ready;
   assign clamped   = (req_data.cylinder > max_ff) ? max_ff : req_data.cylinder;
   assign count_in  = count_ff + CW'(1);
   assign close     = req_data.last_request || count_in == CW'(BATCH_DEPTH);
   assign issuing   = state_ff == S_SCAN && issue_ff < n_ff;
   assign cand_ok   = rd_valid_ff && !marks_ff[rd_idx_ff];
   assign emit      = state_ff == S_EMIT && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   dss_pick u_pick (
      .alg(alg_ff), .head(head_ff), .cand_ok(cand_ok), .cand_cyl(rd_data_ff),
      .cur(pick_ff), .take(take)
   );

   always_comb begin
      best_idx = pick_ff.sel_found ? sel_idx_ff : wrap_idx_ff;
      best_cyl = pick_ff.sel_found ? pick_ff.sel_cyl : pick_ff.wrap_cyl;
      dist_neg = 1'b0;
      if (pick_ff.sel_found) begin
         dist20 = {4'd0, dss_pkg::abs_diff(head_ff, pick_ff.sel_cyl)};
      end else if (alg_ff == dss_pkg::ALG_CLOOK) begin
         dist20 = {4'd0, pick_ff.wrap_cyl - head_ff};
      end else begin
         dist20 = {4'd0, head_ff} + {3'd0, max_ff, 1'b0} - {4'd0, pick_ff.wrap_cyl};
         dist_neg = dist20[19];
      end
      sum = {1'b0, total_ff} + {7'd0, dist20[17:0]};
      rsp_in.served_cylinder = best_cyl;
      rsp_in.step_distance   = dist20[17:0];
      rsp_in.total_distance  = (dist_neg || sum > {1'b0, dss_pkg::TOTAL_MAX}) ?
                               dss_pkg::TOTAL_MAX : sum[23:0];
      rsp_in.last_of_run     = k_ff == n_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem[count_ff[IW-1:0]] <= clamped;
      end
      rd_data_ff <= mem[issue_ff[IW-1:0]];
      rd_idx_ff  <= issue_ff[IW-1:0];
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         alg_ff       <= dss_pkg::ALG_FCFS;
         max_ff       <= dss_pkg::MAX_CYL_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         n_ff         <= '0;
         issue_ff     <= '0;
         k_ff         <= '0;
         marks_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         pick_ff      <= '0;
         sel_idx_ff   <= '0;
         wrap_idx_ff  <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issuing;
         if (issuing) begin
            issue_ff <= issue_ff + CW'(1);
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_LOAD: begin
               if (accept) begin
                  if (close) begin
                     n_ff     <= count_in;
                     count_ff <= '0;
                     state_ff <= S_SCAN;
                     issue_ff <= '0;
                     pick_ff  <= '0;
                     total_ff <= '0;
                     k_ff     <= '0;
                     marks_ff <= '0;
                  end else begin
                     count_ff <= count_in;
                  end
               end
            end
            S_SCAN: begin
               if (take.take_sel) begin
                  pick_ff.sel_found <= 1'b1;
                  pick_ff.sel_cyl   <= rd_data_ff;
                  pick_ff.sel_dist  <= dss_pkg::abs_diff(head_ff, rd_data_ff);
                  sel_idx_ff        <= rd_idx_ff;
               end
               if (take.take_wrap) begin
                  pick_ff.wrap_found <= 1'b1;
                  pick_ff.wrap_cyl   <= rd_data_ff;
                  wrap_idx_ff        <= rd_idx_ff;
               end
               if (rd_valid_ff && CW'(rd_idx_ff) == n_ff - CW'(1)) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (emit) begin
                  marks_ff[best_idx] <= 1'b1;
                  head_ff            <= best_cyl;
                  total_ff           <= rsp_in.total_distance;
                  k_ff               <= k_ff + CW'(1);
                  pick_ff            <= '0;
                  issue_ff           <= '0;
                  state_ff           <= rsp_in.last_of_run ? S_LOAD : S_SCAN;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
         if (csr_we) begin
            unique case (csr_index)
               dss_pkg::CSR_ALGORITHM: alg_ff  <= csr_wdata[1:0];
               dss_pkg::CSR_MAX_CYL:   max_ff  <= csr_wdata;
               dss_pkg::CSR_START:     head_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end
endmodule

>>> sv/dss_checker.sv
// Port checker for the disk seek scheduler, bound to the top level
module dss_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input dss_pkg::rsp_type rsp_data
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");
   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.total_distance >= 24'(rsp_data.step_distance))
      else $error("total below step distance");
   a_no_load_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_of_run |=>
         !req_ready || (rsp_valid && rsp_data.last_of_run))
      else $error("request taken while batch is being served");
endmodule

bind disk_seek_scheduler dss_checker u_dss_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

>>> dv/dss_checker.sv
// Checker: predicts the seek schedule of each batch and compares every result item
module dss_tb_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  dss_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  dss_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   output int               fail_count,
   output int               pending_count
);
   logic [1:0]       alg_q;
   logic [15:0]      max_cyl_q;
   logic [15:0]      head_q;
   logic [15:0]      batch_q[$];
   dss_pkg::rsp_type sched_q[$];

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   task automatic schedule_batch();
      bit [dss_pkg::BatchDepth-1:0] done;
      int               n;
      int               k;
      int               i;
      int               best;
      bit               found;
      int unsigned      step_dist;
      int unsigned      bd;
      int unsigned      d;
      int unsigned      total;
      dss_pkg::rsp_type r;
      done  = '0;
      n     = batch_q.size();
      total = 0;
      for (k = 0; k < n; k++) begin
         best  = 0;
         found = 0;
         bd    = 0;
         if (alg_q == dss_pkg::ALG_FCFS) begin
            for (i = n - 1; i >= 0; i--) if (!done[i]) best = i;
            step_dist = (head_q > batch_q[best]) ? head_q - batch_q[best] :
                                                   batch_q[best] - head_q;
         end else if (alg_q == dss_pkg::ALG_SSTF) begin
            for (i = 0; i < n; i++) begin
               if (done[i]) continue;
               d = (head_q > batch_q[i]) ? head_q - batch_q[i] : batch_q[i] - head_q;
               if (!found || d < bd || (d == bd && batch_q[i] < batch_q[best])) begin
                  best = i; bd = d; found = 1;
               end
            end
            step_dist = bd;
         end else begin
            for (i = 0; i < n; i++) begin
               if (done[i] || batch_q[i] > head_q) continue;
               if (!found || batch_q[i] > batch_q[best]) begin
                  best = i; found = 1;
               end
            end
            if (found) begin
               step_dist = head_q - batch_q[best];
            end else begin
               for (i = 0; i < n; i++) begin
                  if (done[i]) continue;
                  if (!found || batch_q[i] > batch_q[best]) begin
                     best = i; found = 1;
                  end
               end
               if (alg_q == dss_pkg::ALG_CLOOK) step_dist = batch_q[best] - head_q;
               else step_dist = head_q + 2 * max_cyl_q - batch_q[best];
            end
         end
         done[best] = 1;
         head_q     = batch_q[best];
         total      = (step_dist > dss_pkg::TOTAL_MAX - total) ? dss_pkg::TOTAL_MAX :
                                                                 total + step_dist;
         r.served_cylinder = head_q;
         r.step_distance   = step_dist[17:0];
         r.total_distance  = total[23:0];
         r.last_of_run     = (k == n - 1);
         sched_q.push_back(r);
      end
      batch_q.delete();
   endtask

   always @(posedge clock) begin
      dss_pkg::rsp_type exp_r;
      if (reset) begin
         alg_q      = dss_pkg::ALG_FCFS;
         max_cyl_q  = dss_pkg::MAX_CYL_RESET;
         head_q     = '0;
         fail_count = 0;
         batch_q.delete();
         sched_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sched_q.size() == 0) begin
               report("result item with nothing expected");
            end else begin
               exp_r = sched_q.pop_front();
               if (rsp_data.served_cylinder !== exp_r.served_cylinder)
                  report($sformatf("served_cylinder %0d, expected %0d",
                         rsp_data.served_cylinder, exp_r.served_cylinder));
               if (rsp_data.step_distance !== exp_r.step_distance)
                  report($sformatf("step_distance %0d, expected %0d",
                         rsp_data.step_distance, exp_r.step_distance));
               if (rsp_data.total_distance !== exp_r.total_distance)
                  report($sformatf("total_distance %0d, expected %0d",
                         rsp_data.total_distance, exp_r.total_distance));
               if (rsp_data.last_of_run !== exp_r.last_of_run)
                  report($sformatf("last_of_run %0b, expected %0b",
                         rsp_data.last_of_run, exp_r.last_of_run));
            end
         end
         if (req_valid && req_ready) begin
            batch_q.push_back(req_data.cylinder > max_cyl_q ? max_cyl_q : req_data.cylinder);
            if (req_data.last_request || batch_q.size() >= dss_pkg::BatchDepth)
               schedule_batch();
         end
         if (csr_we) begin
            case (csr_index)
               dss_pkg::CSR_ALGORITHM: alg_q = csr_wdata[1:0];
               dss_pkg::CSR_MAX_CYL:   max_cyl_q = csr_wdata;
               dss_pkg::CSR_START:     head_q = csr_wdata;
               default: ;
            endcase
         end
      end
      pending_count = sched_q.size();
   end
endmodule

>>> dv/tb_top.sv
// Testbench top: drives request items and register writes, gives the verdict
module tb_top;
   localparam int StallLimit = 4000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   dss_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   dss_pkg::rsp_type rsp_data;
   logic             csr_we;
   logic [1:0]       csr_index;
   logic [15:0]      csr_wdata;
   int               fail_count;
   int               pending_count;
   int               send_idle;
   int               recv_idle;
   int               quiet_cycles;

   disk_seek_scheduler dut (.*);

   dss_tb_checker u_checker (.*);

   always begin
      clock = 1'b0; #6;
      clock = 1'b1; #6;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [15:0] cyl, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{cylinder: cyl, last_request: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_batch(input logic [15:0] max_cyl);
      int          n;
      int          i;
      logic [15:0] c;
      n = $urandom_range(1, 9);
      for (i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: c = 16'($urandom);
            1: c = 16'($urandom_range(max_cyl));
            2: c = (i > 0 && $urandom_range(1) != 0) ? c : max_cyl;
            default: c = 16'($urandom_range(0, 3));
         endcase
         send_request(c, i == n - 1);
      end
   endtask

   initial begin
      int i;
      int phase;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle = 38;
      recv_idle = 68;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed: FCFS defaults, full store closes, clamp, duplicates
      send_request(16'd0, 1'b0);
      send_request(16'hFFFF, 1'b0);
      send_request(16'd1999, 1'b1);
      for (i = 0; i < 8; i++) send_request(16'd100 * i[15:0], 1'b0);
      write_reg(dss_pkg::CSR_ALGORITHM, 16'(dss_pkg::ALG_SSTF));
      send_request(16'd50, 1'b0);
      send_request(16'd50, 1'b0);
      send_request(16'd40, 1'b0);
      send_request(16'd60, 1'b1);
      write_reg(dss_pkg::CSR_MAX_CYL, 16'hFFFF);
      write_reg(dss_pkg::CSR_START, 16'h8000);
      write_reg(dss_pkg::CSR_ALGORITHM, 16'(dss_pkg::ALG_CLOOK));
      send_request(16'hFFFF, 1'b0);
      send_request(16'h0001, 1'b0);
      send_request(16'h9000, 1'b1);
      write_reg(dss_pkg::CSR_ALGORITHM, 16'(dss_pkg::ALG_CSCAN));
      send_request(16'hFFFF, 1'b0);
      send_request(16'h7000, 1'b0);
      send_request(16'hFFFE, 1'b1);
      write_reg(dss_pkg::CSR_MAX_CYL, 16'd1);
      send_request(16'hAAAA, 1'b0);
      send_request(16'h5555, 1'b1);
      for (phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 38 : (phase == 1) ? 68 : 0;
         recv_idle = (phase == 0) ? 68 : (phase == 1) ? 38 : 0;
         for (i = 0; i < 6; i++) begin
            write_reg(dss_pkg::CSR_ALGORITHM, 16'($urandom_range(3)));
            if ($urandom_range(2) == 0) write_reg(dss_pkg::CSR_START, 16'($urandom));
            if ($urandom_range(3) == 0) begin
               write_reg(dss_pkg::CSR_MAX_CYL, ($urandom_range(1) != 0) ? 16'hFFFF :
                         16'($urandom_range(1, 65535)));
            end
            random_batch(16'hFFFF);
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
